// ===== rtl/core/mclf_pkg.sv =====
// Shared types and constants of the multi-channel LED fader.
`default_nettype none
package mclf_pkg;

  localparam int MAX_CH       = 4;
  localparam int CHANNELS_DEF = 4;
  localparam int CH_W         = 2;
  localparam int LEVEL_W      = 8;
  localparam int MASK_W       = 4;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } mclf_kind_t;

  typedef struct packed {
    mclf_kind_t               kind;
    logic [CH_W-1:0]          channel;
    logic [LEVEL_W-1:0]       target_level;
    logic [LEVEL_W-1:0]       step_count;
    logic [LEVEL_W-1:0]       pause_ticks;
    logic signed [LEVEL_W-1:0] step_delta;
  } mclf_cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               done;
  } mclf_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/mclf_if.sv =====
// Handshake channels of the fader: start/tick words in, level words out.
`default_nettype none
interface mclf_in_if;
  import mclf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [CH_W-1:0]            channel;
  logic [LEVEL_W-1:0]         target_level;
  logic [LEVEL_W-1:0]         step_count;
  logic [LEVEL_W-1:0]         pause_ticks;
  logic signed [LEVEL_W-1:0]  step_delta;

  modport source (output valid, kind, channel, target_level, step_count, pause_ticks,
                  step_delta, input ready);
  modport sink (input valid, kind, channel, target_level, step_count, pause_ticks,
                step_delta, output ready);
endinterface

interface mclf_out_if;
  import mclf_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_0;
  logic [LEVEL_W-1:0] level_1;
  logic [LEVEL_W-1:0] level_2;
  logic [LEVEL_W-1:0] level_3;
  logic [MASK_W-1:0]  done_mask;

  modport source (output valid, level_0, level_1, level_2, level_3, done_mask,
                  input ready);
  modport sink (input valid, level_0, level_1, level_2, level_3, done_mask,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mclf_channel.sv =====
// One fader channel: fade state and its per-word update.
`default_nettype none
module mclf_channel #(
  parameter int CH_IDX = 0
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 fire,
  input  wire mclf_pkg::mclf_cmd_t cmd,
  output mclf_pkg::mclf_stat_t stat_nxt
);
  import mclf_pkg::*;

  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [LEVEL_W-1:0] goal_r, goal_nxt;
  logic               done_r, done_nxt;
  logic [LEVEL_W-1:0] steps_r, steps_nxt;
  logic [LEVEL_W-1:0] reload_r, reload_nxt;
  logic [LEVEL_W-1:0] pause_r, pause_nxt;
  logic [LEVEL_W-1:0] delta_r, delta_nxt;

  logic               start_hit;
  logic               tick_hit;
  logic [LEVEL_W-1:0] pause_dec;
  logic [LEVEL_W-1:0] steps_dec;
  logic signed [LEVEL_W+1:0] sum;

  assign start_hit = (cmd.kind == KIND_START) && (cmd.channel == CH_W'(CH_IDX));
  assign tick_hit  = (cmd.kind == KIND_TICK) && !done_r;
  assign pause_dec = pause_r - LEVEL_W'(1);
  assign steps_dec = steps_r - LEVEL_W'(1);
  assign sum = $signed({2'b00, level_r}) + $signed({{2{delta_r[LEVEL_W-1]}}, delta_r});

  always_comb begin
    level_nxt  = level_r;
    goal_nxt   = goal_r;
    done_nxt   = done_r;
    steps_nxt  = steps_r;
    reload_nxt = reload_r;
    pause_nxt  = pause_r;
    delta_nxt  = delta_r;
    if (start_hit) begin
      goal_nxt   = cmd.target_level;
      steps_nxt  = cmd.step_count;
      reload_nxt = cmd.pause_ticks;
      pause_nxt  = cmd.pause_ticks;
      delta_nxt  = cmd.step_delta;
      done_nxt   = 1'b0;
    end else if (tick_hit) begin
      if (pause_dec != '0) begin
        pause_nxt = pause_dec;
      end else begin
        pause_nxt = reload_r;
        steps_nxt = steps_dec;
        if (steps_dec == '0) begin
          level_nxt = goal_r;
          done_nxt  = 1'b1;
        end else if (sum[LEVEL_W+1] || sum[LEVEL_W]) begin
          // snap to goal on overflow or underflow
          level_nxt = goal_r;
          done_nxt  = 1'b1;
        end else begin
          level_nxt = sum[LEVEL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      goal_r   <= '0;
      done_r   <= 1'b1;
      steps_r  <= '0;
      reload_r <= '0;
      pause_r  <= '0;
      delta_r  <= '0;
    end else if (fire) begin
      level_r  <= level_nxt;
      goal_r   <= goal_nxt;
      done_r   <= done_nxt;
      steps_r  <= steps_nxt;
      reload_r <= reload_nxt;
      pause_r  <= pause_nxt;
      delta_r  <= delta_nxt;
    end
  end

  assign stat_nxt.level = level_nxt;
  assign stat_nxt.done  = done_nxt;

endmodule
`default_nettype wire

// ===== rtl/core/multi_channel_led_fader_unit.sv =====
// Top level of the multi-channel LED fader: input register, channel update, result register.
//
//   port    dir  contents
//   in_if   in   kind, channel, target_level, step_count, pause_ticks, step_delta
//   out_if  out  level_0..level_3, done_mask
//
// Each accepted word gives one result word; one word per cycle while out_if.ready holds.
// The input register and the result register form a two-stage pipeline; the channel
// state updates as a word moves from the input register into the result register.
// A stalled result holds both stages; in_if.ready drops only when both are full.
// Reset (rst_n, synchronous) sets all levels to zero and all channels done.
`default_nettype none
module multi_channel_led_fader_unit #(
  parameter int CHANNELS = mclf_pkg::CHANNELS_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  mclf_in_if.sink   in_if,
  mclf_out_if.source out_if
);
  import mclf_pkg::*;

  logic       in_valid_r;
  mclf_cmd_t  in_cmd_r;
  logic       out_valid_r;
  logic [LEVEL_W-1:0] out_level_r [MAX_CH];
  logic [MASK_W-1:0]  out_mask_r;

  logic       out_free;
  logic       fire;
  logic       in_take;
  mclf_stat_t stat_nxt [MAX_CH];
  logic [LEVEL_W-1:0] level_nxt [MAX_CH];
  logic [MASK_W-1:0]  mask_nxt;

  assign out_free    = !out_valid_r || out_if.ready;
  assign fire        = in_valid_r && out_free;
  assign in_if.ready = !in_valid_r || out_free;
  assign in_take     = in_if.valid && in_if.ready;

  for (genvar c = 0; c < MAX_CH; c++) begin : g_ch
    if (c < CHANNELS) begin : g_on
      mclf_channel #(.CH_IDX(c)) u_ch (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .cmd      (in_cmd_r),
        .stat_nxt (stat_nxt[c])
      );
      assign level_nxt[c] = stat_nxt[c].level;
      assign mask_nxt[c]  = stat_nxt[c].done;
    end else begin : g_off
      assign stat_nxt[c]  = '0;
      assign level_nxt[c] = stat_nxt[c].level;
      assign mask_nxt[c]  = stat_nxt[c].done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
    if (in_take) begin
      in_cmd_r.kind         <= mclf_kind_t'(in_if.kind);
      in_cmd_r.channel      <= in_if.channel;
      in_cmd_r.target_level <= in_if.target_level;
      in_cmd_r.step_count   <= in_if.step_count;
      in_cmd_r.pause_ticks  <= in_if.pause_ticks;
      in_cmd_r.step_delta   <= in_if.step_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
    if (fire) begin
      out_level_r <= level_nxt;
      out_mask_r  <= mask_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.level_0   = out_level_r[0];
  assign out_if.level_1   = out_level_r[1];
  assign out_if.level_2   = out_level_r[2];
  assign out_if.level_3   = out_level_r[3];
  assign out_if.done_mask = out_mask_r;

endmodule
`default_nettype wire
